/* rtl/rsm_pkg.sv */
package rsm_pkg;
   localparam int unsigned LOG2E_Q16 = 94548;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam int unsigned DIFF_W = 17;
   localparam int unsigned U_W = 34;
   localparam int unsigned P_W = 31;
   // ceil(2^33 / k), exact floor quotient for operands below 2^30
   localparam logic [31:0] RECIP3 = 32'd2863311531;
   localparam logic [31:0] RECIP5 = 32'd1717986919;
   localparam logic [31:0] RECIP6 = 32'd1431655766;

   typedef struct packed {
      logic start;
      logic [16:0] diff;
   } exp_req_type;
endpackage

/* rtl/rsm_exp_unit.sv */
module rsm_exp_unit import rsm_pkg::*; #(
   parameter int EXP_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  exp_req_type req,
   output logic done,
   output logic [EXP_FRAC_BITS:0] term
);
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_Y = 3'd2, S_H1 = 3'd3,
      S_H2 = 3'd4, S_H3 = 3'd5, S_OUT = 3'd6;
   logic [2:0] st_ff, st_in;
   logic [16:0] d_ff, d_in;
   logic [33:0] u_ff, u_in;
   logic [29:0] y_ff, y_in;
   logic [31:0] p_ff, p_in;
   logic [61:0] prod_ff, prod_in;
   logic [2:0] k_ff, k_in;
   logic [EXP_FRAC_BITS:0] term_ff, term_in;
   logic done_ff, done_in;
   logic [31:0] tq;
   logic [31:0] ysh;
   logic [31:0] rm;
   logic [63:0] rq;
   logic [9:0] nn;
   logic [10:0] s;
   logic [32:0] pr;

   always_comb begin
      ysh = 32'(prod_ff >> 30);
      case (k_ff)
         3'd3: rm = RECIP3;
         3'd5: rm = RECIP5;
         3'd6: rm = RECIP6;
         default: rm = '0;
      endcase
      rq = 64'(ysh) * 64'(rm);
      case (k_ff)
         3'd1: tq = ysh;
         3'd2: tq = ysh >> 1;
         3'd3: tq = 32'(rq >> 33);
         3'd4: tq = ysh >> 2;
         3'd5: tq = 32'(rq >> 33);
         3'd6: tq = 32'(rq >> 33);
         default: tq = ysh;
      endcase
      nn = u_ff[33:24];
      s = 11'(nn) + 11'(30 - EXP_FRAC_BITS);
      pr = 33'(p_ff) + (33'd1 << (s[5:0] - 6'd1));
   end

   always_comb begin
      st_in = st_ff; d_in = d_ff; u_in = u_ff; y_in = y_ff; p_in = p_ff;
      prod_in = prod_ff; k_in = k_ff; term_in = term_ff; done_in = 1'b0;
      case (st_ff)
         S_IDLE: if (req.start) begin
            d_in = req.diff; st_in = S_MUL;
         end
         S_MUL: begin
            u_in = 34'(d_ff) * 34'(LOG2E_Q16); st_in = S_Y;
         end
         S_Y: begin
            prod_in = 62'(u_ff[23:0]) * 62'(LN2_Q30); st_in = S_H1;
         end
         S_H1: begin
            y_in = 30'(prod_ff >> 24); p_in = ONE_Q30; k_in = 3'd6; st_in = S_H2;
         end
         S_H2: begin
            prod_in = 62'(y_ff) * 62'(p_ff); st_in = S_H3;
         end
         S_H3: begin
            p_in = (tq >= ONE_Q30) ? 32'd0 : ONE_Q30 - tq;
            k_in = k_ff - 3'd1;
            st_in = (k_ff == 3'd1) ? S_OUT : S_H2;
         end
         S_OUT: begin
            term_in = (s >= 11'd40) ? '0 : (EXP_FRAC_BITS+1)'(pr >> s[5:0]);
            done_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; done_ff <= done_in;
      end
      d_ff <= d_in; u_ff <= u_in; y_ff <= y_in; p_ff <= p_in;
      prod_ff <= prod_in; k_ff <= k_in; term_ff <= term_in;
   end
   assign done = done_ff;
   assign term = term_ff;
endmodule

/* rtl/rsm_divider.sv */
module rsm_divider #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic done,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0] rs;

   always_comb begin
      q_in = q_ff; r_in = r_ff; c_in = c_ff; busy_in = busy_ff; done_in = 1'b0;
      rs = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; r_in = '0; c_in = CW'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rs >= {1'b0, den}) begin
            r_in = rs - {1'b0, den}; q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = rs; q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         c_in = c_ff - 1'b1;
         if (c_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; c_ff <= c_in;
   end
   assign done = done_ff;
   assign quo = q_ff;
endmodule

/* rtl/row_softmax_fixed.sv */
// Loading: one element per cycle, req_stall low while collecting once the
// previous row's last result has left. Row end: exponents element by element
// (six Horner passes), then for each element a serial divide and the
// result beat when rsp_stall is low. Results leave through an output register;
// req_stall high until the row drains.
// Synchronous active-high reset clears count, overflow and control and sets max to -32768.
module row_softmax_fixed import rsm_pkg::*; #(
   parameter int ROW_MAX = 64,
   parameter int EXP_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_value,
   input  logic req_row_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_prob,
   output logic rsp_last_of_row,
   output logic rsp_truncated
);
   localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int CW = $clog2(ROW_MAX + 1);
   localparam int EW = EXP_FRAC_BITS + 1;
   localparam int SW = EW + 7;
   localparam int NW = EW + 17;
   localparam logic [2:0] S_LOAD = 3'd0, S_ERD = 3'd1, S_EWT = 3'd2,
      S_DRD = 3'd3, S_DST = 3'd4, S_DWT = 3'd5, S_OUT = 3'd6, S_EST = 3'd7;

   logic signed [15:0] row_mem [ROW_MAX];
   logic [EW-1:0] exp_mem [ROW_MAX];
   logic [2:0] st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic signed [15:0] max_ff, max_in;
   logic ovf_ff, ovf_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic signed [15:0] rd_ff;
   logic [EW-1:0] erd_ff;
   logic ov_ff, ov_in, olast_ff, olast_in, otr_ff, otr_in;
   logic [15:0] oprob_ff, oprob_in;
   logic exp_done, div_done, div_start, exp_start;
   logic [EW-1:0] term;
   logic [NW-1:0] quo;
   logic acc;
   exp_req_type ereq;

   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != S_LOAD) || ov_ff;

   always_ff @(posedge clock) begin
      if (acc && cnt_ff < CW'(ROW_MAX)) row_mem[cnt_ff[AW-1:0]] <= req_value;
      if (exp_done) exp_mem[idx_ff[AW-1:0]] <= term;
      rd_ff <= row_mem[idx_ff[AW-1:0]];
      erd_ff <= exp_mem[idx_ff[AW-1:0]];
   end

   assign exp_start = (st_ff == S_EST);
   assign ereq.start = exp_start;
   assign ereq.diff = 17'(max_ff) - 17'(rd_ff);
   assign div_start = (st_ff == S_DST) && sum_ff != '0;

   rsm_exp_unit #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_exp (
      .clock(clock), .reset(reset), .req(ereq), .done(exp_done), .term(term));

   rsm_divider #(.NUM_W(NW), .DEN_W(SW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(NW'({erd_ff, 16'd0}) + NW'(sum_ff >> 1)), .den(sum_ff),
      .done(div_done), .quo(quo));

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; idx_in = idx_ff; max_in = max_ff;
      ovf_in = ovf_ff; sum_in = sum_ff; ov_in = ov_ff; oprob_in = oprob_ff;
      olast_in = olast_ff; otr_in = otr_ff;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (st_ff)
         S_LOAD: if (acc) begin
            if (cnt_ff < CW'(ROW_MAX)) begin
               cnt_in = cnt_ff + 1'b1;
               if (req_value > max_ff) max_in = req_value;
            end else begin
               ovf_in = 1'b1;
            end
            if (req_row_end) begin
               idx_in = '0; sum_in = '0; st_in = S_ERD;
            end
         end
         S_ERD: st_in = S_EST;
         S_EST: st_in = S_EWT;
         S_EWT: if (exp_done) begin
            sum_in = sum_ff + SW'(term);
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in = '0; st_in = S_DRD;
            end else st_in = S_ERD;
         end
         S_DRD: if (!ov_in) st_in = S_DST;
         S_DST: begin
            if (sum_ff == '0) begin
               oprob_in = '0; st_in = S_OUT;
            end else st_in = S_DWT;
         end
         S_DWT: if (div_done) begin
            oprob_in = (quo > NW'(65535)) ? 16'hFFFF : quo[15:0];
            st_in = S_OUT;
         end
         S_OUT: begin
            ov_in = 1'b1;
            olast_in = (idx_ff + 1'b1 == cnt_ff);
            otr_in = ovf_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == cnt_ff) begin
               st_in = S_LOAD; cnt_in = '0; max_in = -16'sd32768; ovf_in = 1'b0;
            end else st_in = S_DRD;
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; cnt_ff <= '0; max_ff <= -16'sd32768; ovf_ff <= 1'b0;
         ov_ff <= 1'b0; idx_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; max_ff <= max_in; ovf_ff <= ovf_in;
         ov_ff <= ov_in; idx_ff <= idx_in;
      end
      sum_ff <= sum_in; oprob_ff <= oprob_in; olast_ff <= olast_in; otr_ff <= otr_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_prob = oprob_ff;
   assign rsp_last_of_row = olast_ff;
   assign rsp_truncated = otr_ff;

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(ROW_MAX)) else $error("count over capacity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prob))
      else $error("result lost");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_LOAD |-> req_stall) else $error("accept while busy");
`endif
endmodule
